/* hdl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the strict UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // width of the saturating unit counter
  localparam int COUNT_WIDTH = 24;

  // results one byte can cause: two code units and a summary
  localparam int RES_SLOTS = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ENCODING  = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0]            code_unit;
    logic                   unit_valid;
    logic                   string_done;
    status_t                status;
    logic [COUNT_WIDTH-1:0] units_count;
    logic                   last_of_run;
  } result_t;

  // all results of one byte, slot 0 first, plus how many are used
  typedef struct packed {
    result_t [RES_SLOTS-1:0] slot;
    logic [1:0]              count;
  } res_pack_t;

endpackage

/* hdl/strict_utf8_to_utf16_decoder_core.sv */
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_decoder_core
// Strict UTF-8 to UTF-16 decoder, one byte per transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one byte of a UTF-8 string; end_of_string marks
// the last byte. Bytes are gathered into sequences of one to four bytes and
// each good sequence yields one UTF-16 unit or a surrogate pair. Bad leads,
// bad continuations, overlong forms, surrogate code points and values above
// U+10FFFF are refused with an encoding error; a bad continuation is flagged
// only once the sequence's full length has gone by, so a string that ends
// inside a sequence reports truncated. After an error the remaining bytes of
// the string are dropped. The last byte also yields a summary result
// (string_done = 1) with the status and the saturating unit count; then all
// sequence state clears for the next string. last_of_run marks the final
// result caused by a byte.
// Rate: a byte is decoded in the cycle it leaves the input register, and
// its results land in the result register. A byte giving zero or one result
// lets the block run at one byte per cycle while results are taken; a byte
// giving two or three results (surrogate pair, summary) holds the decoder
// for that many output transfers, as the result register hands out one result
// per accepted transfer. Each byte passes the input, then the result register.
// ----------------------------------------------------------------------------
module strict_utf8_to_utf16_decoder_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               end_of_string,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [15:0]                        code_unit,
  output logic                               unit_valid,
  output logic                               string_done,
  output logic [1:0]                         status,
  output logic [u8u16_pkg::COUNT_WIDTH-1:0]  units_count,
  output logic                               last_of_run
);
  import u8u16_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       eos_q;

  // decode -> result register
  logic      load;
  logic      can_load;
  res_pack_t pack;
  result_t   head;

  // a held byte moves on once the result register is free for its results
  assign load     = in_full && can_load;
  // take a new byte whenever the input register is empty or empties now
  assign in_ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
      eos_q  <= end_of_string;
    end
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  u8u16_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .in_byte       (byte_q),
    .end_of_string (eos_q),
    .pack          (pack)
  );

  u8u16_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .pack      (pack),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .head      (head)
  );

  // result fields straight from the result register
  assign code_unit   = head.code_unit;
  assign unit_valid  = head.unit_valid;
  assign string_done = head.string_done;
  assign status      = head.status;
  assign units_count = head.units_count;
  assign last_of_run = head.last_of_run;

endmodule

/* hdl/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode: gathers the code point, checks it and
// builds the results of one byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_string,
  output u8u16_pkg::res_pack_t pack
);
  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE    = 2'd0,
    M_COLLECT = 2'd1,
    M_BAD     = 2'd2,
    M_DISCARD = 2'd3
  } mode_t;

  mode_t                  mode, mode_next, mode_w;
  logic [20:0]            acc, acc_next, acc_w;
  logic [1:0]             bytes_left, bytes_left_next;
  logic [1:0]             seq_length, seq_length_next;
  logic [COUNT_WIDTH-1:0] unit_total, unit_total_next;
  logic [COUNT_WIDTH-1:0] t1, t2, tsum;
  logic [1:0]             nu;
  logic [15:0]            u0, u1;
  logic [20:0]            lowest;
  logic [19:0]            v;
  status_t                sum_status;
  result_t                r_u0, r_u1, r_sum;
  logic [1:0]             cnt;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
    sat_inc = (&x) ? x : x + 1'b1;
  endfunction

  always_comb begin
    mode_next       = mode;
    acc_next        = acc;
    bytes_left_next = bytes_left;
    seq_length_next = seq_length;
    mode_w          = mode;
    acc_w           = acc;
    nu              = 2'd0;
    u0              = 16'h0000;
    u1              = 16'h0000;
    lowest          = 21'h10000;
    v               = acc[19:0] - 20'h10000;
    unique case (mode)
      M_IDLE: begin
        if (!in_byte[7]) begin
          nu = 2'd1;
          u0 = {8'h00, in_byte};
        end else if (in_byte[7:5] == 3'b110) begin
          acc_next = {16'h0000, in_byte[4:0]};
          seq_length_next = 2'd1;
          bytes_left_next = 2'd1;
          mode_next = M_COLLECT;
        end else if (in_byte[7:4] == 4'b1110) begin
          acc_next = {17'h00000, in_byte[3:0]};
          seq_length_next = 2'd2;
          bytes_left_next = 2'd2;
          mode_next = M_COLLECT;
        end else if (in_byte[7:3] == 5'b11110) begin
          acc_next = {18'h00000, in_byte[2:0]};
          seq_length_next = 2'd3;
          bytes_left_next = 2'd3;
          mode_next = M_COLLECT;
        end else begin
          mode_next = M_DISCARD;
        end
      end
      M_COLLECT, M_BAD: begin
        if (mode == M_COLLECT) begin
          if (in_byte[7:6] != 2'b10) begin
            mode_w = M_BAD;
          end else begin
            acc_w = {acc[14:0], in_byte[5:0]};
          end
        end
        bytes_left_next = bytes_left - 2'd1;
        v = acc_w[19:0] - 20'h10000;
        unique case (seq_length)
          2'd1:    lowest = 21'h00080;
          2'd2:    lowest = 21'h00800;
          default: lowest = 21'h10000;
        endcase
        if (bytes_left_next == 2'd0) begin
          if (mode_w == M_BAD || acc_w < lowest || acc_w > 21'h10FFFF ||
              (acc_w >= 21'h00D800 && acc_w <= 21'h00DFFF)) begin
            mode_next = M_DISCARD;
          end else begin
            mode_next = M_IDLE;
            if (acc_w < 21'h10000) begin
              nu = 2'd1;
              u0 = acc_w[15:0];
            end else begin
              // surrogate pair
              nu = 2'd2;
              u0 = {6'b110110, v[19:10]};
              u1 = {6'b110111, v[9:0]};
            end
          end
          acc_next = '0;
          seq_length_next = 2'd0;
        end else begin
          mode_next = mode_w;
          acc_next  = acc_w;
        end
      end
      default: begin
        // discarding: wait for the end mark
      end
    endcase

    t1 = sat_inc(unit_total);
    t2 = sat_inc(t1);
    unique case (nu)
      2'd0:    tsum = unit_total;
      2'd1:    tsum = t1;
      default: tsum = t2;
    endcase
    unit_total_next = tsum;

    unique case (mode_next)
      M_IDLE:    sum_status = ST_OK;
      M_DISCARD: sum_status = ST_ENCODING;
      default:   sum_status = ST_TRUNCATED;
    endcase

    if (end_of_string) begin
      mode_next       = M_IDLE;
      acc_next        = '0;
      bytes_left_next = 2'd0;
      seq_length_next = 2'd0;
      unit_total_next = '0;
    end

    r_u0  = '{code_unit: u0, unit_valid: 1'b1, string_done: 1'b0, status: ST_OK,
              units_count: t1, last_of_run: 1'b0};
    r_u1  = '{code_unit: u1, unit_valid: 1'b1, string_done: 1'b0, status: ST_OK,
              units_count: t2, last_of_run: 1'b0};
    r_sum = '{code_unit: 16'h0000, unit_valid: 1'b0, string_done: 1'b1,
              status: sum_status, units_count: tsum, last_of_run: 1'b0};

    cnt = nu + {1'b0, end_of_string};
    pack.count   = cnt;
    pack.slot[0] = (nu != 2'd0) ? r_u0 : r_sum;
    pack.slot[1] = (nu == 2'd2) ? r_u1 : r_sum;
    pack.slot[2] = r_sum;
    pack.slot[0].last_of_run = (cnt == 2'd1);
    pack.slot[1].last_of_run = (cnt == 2'd2);
    pack.slot[2].last_of_run = (cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      acc        <= '0;
      bytes_left <= 2'd0;
      seq_length <= 2'd0;
      unit_total <= '0;
    end else if (load) begin
      mode       <= mode_next;
      acc        <= acc_next;
      bytes_left <= bytes_left_next;
      seq_length <= seq_length_next;
      unit_total <= unit_total_next;
    end
  end

endmodule

/* hdl/u8u16_outbuf.sv */
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Result register: holds the results of one byte and hands them out one
// transfer at a time.
// ----------------------------------------------------------------------------
module u8u16_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  u8u16_pkg::res_pack_t pack,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output u8u16_pkg::result_t   head
);
  import u8u16_pkg::*;

  result_t [RES_SLOTS-1:0] slots;
  logic [1:0]              cnt;
  logic [1:0]              ptr;

  assign out_valid = (cnt != 2'd0);
  // free now, or the last held result leaves this cycle
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);

  always_comb begin
    unique case (ptr)
      2'd0:    head = slots[0];
      2'd1:    head = slots[1];
      default: head = slots[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= pack.slot;
    end
    if (rst) begin
      cnt <= 2'd0;
      ptr <= 2'd0;
    end else if (load) begin
      cnt <= pack.count;
      ptr <= 2'd0;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - 2'd1;
      ptr <= ptr + 2'd1;
    end
  end

endmodule

/* hdl/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks of the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [15:0]                       code_unit,
  input logic                              unit_valid,
  input logic                              string_done,
  input logic [1:0]                        status,
  input logic [u8u16_pkg::COUNT_WIDTH-1:0] units_count,
  input logic                              last_of_run
);
  import u8u16_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_unit) &&
    $stable(units_count) && $stable(string_done))
    else $error("result changed while stalled");

  // summary carries no unit and closes the byte's run
  a_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> !unit_valid && code_unit == 16'h0000 && last_of_run)
    else $error("malformed summary");

  // unit results report ok status
  a_unit_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_valid |-> !string_done && status == ST_OK)
    else $error("unit result with nonzero status");

  // a non-summary result that directly follows a unit transfer has a nonzero count
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && unit_valid ##1 out_valid && !string_done |->
    units_count != 0)
    else $error("unit count lost within a string");

endmodule

bind strict_utf8_to_utf16_decoder_core u8u16_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .code_unit   (code_unit),
  .unit_valid  (unit_valid),
  .string_done (string_done),
  .status      (status),
  .units_count (units_count),
  .last_of_run (last_of_run)
);
